### rtl/rsc_pkg.sv
// Shared types, constants and character helpers for the radix string converter.
// No dependencies; every other file in rtl/ but rsc_checker.sv imports this package.
package rsc_pkg;

  // Fixed field and datapath widths.
  localparam int BASE_W    = 5;
  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 64;
  localparam int DIG_W     = 6;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_BITS_PER_STEP = 8;
  localparam int DIV_STEPS         = VALUE_W / DIV_BITS_PER_STEP;
  localparam int STEP_W            = $clog2(DIV_STEPS);

  // ASCII codes and base values.
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;
  localparam logic [DIG_W-1:0]  DIGIT_TEN = 6'd10;
  localparam logic [BASE_W-1:0] SRC_BASE_RESET = 5'd10;
  localparam logic [BASE_W-1:0] TGT_BASE_RESET = 5'd10;
  localparam logic [BASE_W-1:0] MIN_TGT_BASE   = 5'd2;
  localparam logic [BASE_W-1:0] LAST_DEC_DIGIT = 5'd9;

  // Register map, indexed by paddr[2].
  typedef enum logic {
    REG_SOURCE_BASE = 1'b0,
    REG_TARGET_BASE = 1'b1
  } rsc_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_EMIT
  } rsc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;          // an input character is transferred
    logic post_illegal;  // present the illegal-number result next cycle
    logic load_div;      // load the finished value into the divider
    logic div_step;      // retire one group of quotient bits
    logic store;         // write the remainder digit to the buffer
    logic emit_rd;       // read one buffered digit and present it
  } rsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_next;      // number is illegal once this character is counted
    logic last_in;       // the offered character closes the number
    logic div_done;      // the current division finishes this cycle
    logic more_digits;   // another output digit must be produced
    logic rd_last;       // the read being issued is the final digit
  } rsc_sts_t;

  // True for '0'-'9' and 'A'-'Z'.
  function automatic logic char_is_digit(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) || ((c >= CHAR_A) && (c <= CHAR_Z));
  endfunction

  // Digit value of a character; meaningful only where char_is_digit holds.
  function automatic logic [DIG_W-1:0] decode_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    if (c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
      return diff[DIG_W-1:0];
    end else begin
      diff = c - CHAR_A;
      return diff[DIG_W-1:0] + DIGIT_TEN;
    end
  endfunction

  // ASCII character for one output digit.
  function automatic logic [CHAR_W-1:0] encode_digit(input logic [BASE_W-1:0] d);
    if (d > LAST_DEC_DIGIT) begin
      return CHAR_A + CHAR_W'(d - 5'd10);
    end else begin
      return CHAR_ZERO + CHAR_W'(d);
    end
  endfunction

endpackage

### rtl/rsc_regs.sv
// Configuration registers of the radix string converter behind an APB-style port.
// Depends on rsc_pkg for widths, reset values and the register map.
module rsc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsc_pkg::PADDR_W-1:0] paddr,
  input  logic [rsc_pkg::PDATA_W-1:0] pwdata,
  output logic [rsc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [rsc_pkg::BASE_W-1:0]  source_base,
  output logic [rsc_pkg::BASE_W-1:0]  target_base
);
  import rsc_pkg::*;

  logic     wr_en;
  rsc_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = rsc_reg_t'(paddr[2]);

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= SRC_BASE_RESET;
      target_base <= TGT_BASE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SOURCE_BASE: source_base <= pwdata[BASE_W-1:0];
        REG_TARGET_BASE: target_base <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (reg_sel)
      REG_SOURCE_BASE: prdata = PDATA_W'(source_base);
      REG_TARGET_BASE: prdata = PDATA_W'(target_base);
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/rsc_ctrl.sv
// Controller state machine of the radix string converter.
// Depends on rsc_pkg for the state, command and status types.
module rsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rsc_pkg::rsc_sts_t sts,
  output rsc_pkg::rsc_cmd_t cmd,
  output logic              busy
);
  import rsc_pkg::*;

  rsc_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.take = 1'b1;
          if (sts.last_in) begin
            if (sts.bad_next) begin
              cmd.post_illegal = 1'b1;
            end else begin
              cmd.load_div = 1'b1;
              state_next   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (sts.more_digits) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_rd = 1'b1;
        if (sts.rd_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/rsc_datapath.sv
// Datapath of the radix string converter: Horner accumulator, digit divider,
// digit buffer and result registers. Depends on rsc_pkg.
module rsc_datapath #(
  parameter int MAX_OUT_DIGITS = 64,
  parameter int MAX_IN_DIGITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rsc_pkg::rsc_cmd_t          cmd,
  output rsc_pkg::rsc_sts_t          sts,
  input  logic [rsc_pkg::BASE_W-1:0] source_base,
  input  logic [rsc_pkg::BASE_W-1:0] target_base,
  input  logic [rsc_pkg::CHAR_W-1:0] digit_char,
  input  logic                       is_last_in,
  output logic                       strobe,
  output logic [rsc_pkg::CHAR_W-1:0] out_char,
  output logic                       illegal,
  output logic                       is_last_out
);
  import rsc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_OUT_DIGITS);
  localparam int NCNT_W = $clog2(MAX_OUT_DIGITS + 1);
  localparam int ICNT_W = $clog2(MAX_IN_DIGITS + 2);

  // Accumulation state.
  logic [VALUE_W-1:0] acc;
  logic               bad;
  logic [ICNT_W-1:0]  count;

  // Divider, buffer and emission state.
  logic [VALUE_W-1:0] quot;
  logic [BASE_W-1:0]  rem;
  logic [STEP_W-1:0]  step;
  logic [NCNT_W-1:0]  ndig;
  logic [ADDR_W-1:0]  rd_idx;
  logic [BASE_W-1:0]  buf_mem [MAX_OUT_DIGITS];
  logic [BASE_W-1:0]  rd_data;
  logic               out_valid;
  logic               out_last;
  logic               out_illegal;

  // Combinational signals.
  logic [DIG_W-1:0]   dval;
  logic               digit_ok;
  logic               count_over;
  logic [ICNT_W-1:0]  count_inc;
  logic [VALUE_W-1:0] acc_next;
  logic [BASE_W-1:0]  div_base;
  logic [DIG_W-1:0]   div_r;
  logic [VALUE_W-1:0] div_q;

  // Character decode and Horner multiply-add.
  assign dval       = decode_value(digit_char);
  assign digit_ok   = char_is_digit(digit_char) && (dval < DIG_W'(source_base));
  assign count_over = (count >= ICNT_W'(MAX_IN_DIGITS));
  assign count_inc  = (count < ICNT_W'(MAX_IN_DIGITS + 1)) ? count + 1'b1 : count;
  assign acc_next   = VALUE_W'(acc * VALUE_W'(source_base)) + VALUE_W'(dval);

  // Status toward the controller.
  assign sts.bad_next    = bad || !digit_ok || count_over;
  assign sts.last_in     = is_last_in;
  assign sts.div_done    = (step == STEP_W'(DIV_STEPS - 1));
  assign sts.more_digits = (quot != '0) && (ndig < NCNT_W'(MAX_OUT_DIGITS - 1));
  assign sts.rd_last     = (rd_idx == '0);

  // Restoring division, one group of quotient bits per cycle.
  assign div_base = (target_base < MIN_TGT_BASE) ? MIN_TGT_BASE : target_base;

  always_comb begin
    div_r = DIG_W'(rem);
    div_q = quot;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      div_r = {div_r[DIG_W-2:0], div_q[VALUE_W-1]};
      div_q = {div_q[VALUE_W-2:0], 1'b0};
      if (div_r >= DIG_W'(div_base)) begin
        div_r    = div_r - DIG_W'(div_base);
        div_q[0] = 1'b1;
      end
    end
  end

  // Number state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      bad       <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (is_last_in) begin
          acc   <= '0;
          bad   <= 1'b0;
          count <= '0;
        end else begin
          if (digit_ok) begin
            acc <= acc_next;
          end
          bad   <= sts.bad_next;
          count <= count_inc;
        end
      end
      out_valid <= cmd.post_illegal || cmd.emit_rd;
    end
  end

  // Divider, buffer pointers and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      quot <= acc_next;
      rem  <= '0;
      step <= '0;
      ndig <= '0;
    end else if (cmd.div_step) begin
      quot <= div_q;
      rem  <= div_r[BASE_W-1:0];
      step <= step + 1'b1;
    end else if (cmd.store) begin
      ndig   <= ndig + 1'b1;
      rd_idx <= ndig[ADDR_W-1:0];
      rem    <= '0;
      step   <= '0;
    end else if (cmd.emit_rd) begin
      rd_idx <= rd_idx - 1'b1;
    end
    if (cmd.post_illegal) begin
      out_last    <= 1'b1;
      out_illegal <= 1'b1;
    end else if (cmd.emit_rd) begin
      out_last    <= sts.rd_last;
      out_illegal <= 1'b0;
    end
  end

  // Digit buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      buf_mem[ndig[ADDR_W-1:0]] <= rem;
    end
    if (cmd.emit_rd) begin
      rd_data <= buf_mem[rd_idx];
    end
  end

  // Result ports.
  assign strobe      = out_valid;
  assign illegal     = out_illegal;
  assign is_last_out = out_last;
  assign out_char    = out_illegal ? '0 : encode_digit(rd_data);

endmodule

### rtl/radix_string_converter.sv
// Top level of the radix string converter: register port, controller and datapath.
// Depends on rsc_pkg, rsc_regs, rsc_ctrl and rsc_datapath.
//
//   Channel   Handshake               Fields
//   input     start high, busy low    digit_char, is_last_in
//   result    strobe, one cycle       out_char, illegal, is_last_out
//   config    psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// A character that is not the last one is taken with busy staying low.
// A last character with an illegal number gives its single result in the next cycle.
// Otherwise each output digit runs the shared divider through division steps of 8
// quotient bits each and one buffer write, then the digits come out one per cycle,
// with busy high until the last read.
// Reset is synchronous; results cannot be held off.
module radix_string_converter #(
  parameter int MAX_OUT_DIGITS = 64,
  parameter int MAX_IN_DIGITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsc_pkg::PADDR_W-1:0] paddr,
  input  logic [rsc_pkg::PDATA_W-1:0] pwdata,
  output logic [rsc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [rsc_pkg::CHAR_W-1:0]  digit_char,
  input  logic                        is_last_in,
  output logic                        strobe,
  output logic [rsc_pkg::CHAR_W-1:0]  out_char,
  output logic                        illegal,
  output logic                        is_last_out
);
  import rsc_pkg::*;

  logic [BASE_W-1:0] source_base;
  logic [BASE_W-1:0] target_base;
  rsc_cmd_t          cmd;
  rsc_sts_t          sts;

  // Configuration registers.
  rsc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .source_base (source_base),
    .target_base (target_base)
  );

  // Sequencing of accumulation, division and emission.
  rsc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Arithmetic, digit buffer and result registers.
  rsc_datapath #(
    .MAX_OUT_DIGITS (MAX_OUT_DIGITS),
    .MAX_IN_DIGITS  (MAX_IN_DIGITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .source_base (source_base),
    .target_base (target_base),
    .digit_char  (digit_char),
    .is_last_in  (is_last_in),
    .strobe      (strobe),
    .out_char    (out_char),
    .illegal     (illegal),
    .is_last_out (is_last_out)
  );

endmodule

### rtl/rsc_checker.sv
// Port-level checks for the radix string converter, bound to its top level.
// Depends only on the top level's ports.
module rsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       is_last_in,
  input logic       strobe,
  input logic [7:0] out_char,
  input logic       illegal,
  input logic       is_last_out
);

  // An illegal result is a single, final transfer with a zero character.
  assert property (@(posedge clk) disable iff (rst)
    strobe && illegal |-> is_last_out && (out_char == 8'h00))
    else $error("illegal result is not a final zero transfer");

  // An illegal result follows directly on the transfer of a last character.
  assert property (@(posedge clk) disable iff (rst)
    strobe && illegal |-> $past(start && !busy && is_last_in))
    else $error("illegal result without a closing character");

  // A digit result carries a valid output digit character.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !illegal |->
      ((out_char >= 8'h30) && (out_char <= 8'h39)) ||
      ((out_char >= 8'h41) && (out_char <= 8'h55)))
    else $error("digit result outside the digit alphabet");

  // While more digits of a number are due, no new character is taken.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !is_last_out |-> busy)
    else $error("block idle in the middle of a result sequence");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("result strobe right after reset");

endmodule

bind radix_string_converter rsc_checker u_rsc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .is_last_in  (is_last_in),
  .strobe      (strobe),
  .out_char    (out_char),
  .illegal     (illegal),
  .is_last_out (is_last_out)
);
